// ----- hdl/erg_pkg.sv -----
package erg_pkg;

	localparam int CountWidth = 16;
	localparam int TickWidth  = 20;
	localparam int TicksWidth = 16;
	localparam int DivWidth   = 8;
	localparam int TenWidth   = 4;
	localparam int FifoDepth  = 4;
	localparam int FifoAw     = $clog2(FifoDepth);

	// longest echo the counter holds
	localparam logic [TickWidth-1:0] CountMax = (CountWidth >= TickWidth) ?
		{TickWidth{1'b1}} : TickWidth'((64'd1 << CountWidth) - 64'd1);
	localparam logic [TickWidth-1:0] TicksSat = TickWidth'({TicksWidth{1'b1}});

	localparam logic [1:0] RegTrigTicks = 2'd0;
	localparam logic [1:0] RegWaitLimit = 2'd1;
	localparam logic [1:0] RegTicksCm   = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_TEN
	} bk_state_t;

	// one tick after classification
	typedef struct packed {
		logic                  trigger;
		logic                  done_res;
		logic                  timed_out;
		logic                  meas;
		logic [TicksWidth-1:0] ticks;
		logic [DivWidth-1:0]   divisor;
	} job_t;

	typedef struct packed {
		logic                  trigger;
		logic                  done_res;
		logic                  timed_out;
		logic [TicksWidth-1:0] echo_ticks;
		logic [TicksWidth-1:0] dist_cm;
		logic [TenWidth-1:0]   dist_tenths;
	} res_t;

endpackage

// ----- hdl/erg_fifo.sv -----
module erg_fifo import erg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	input  logic rd_en,
	output job_t rd_data,
	output logic full,
	output logic empty
);

	job_t               mem_q [FifoDepth];
	logic [FifoAw-1:0]  wr_ptr_q;
	logic [FifoAw-1:0]  rd_ptr_q;
	logic [FifoAw:0]    fill_q;

	assign full    = fill_q == (FifoAw+1)'(FifoDepth);
	assign empty   = fill_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == FifoAw'(FifoDepth-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == FifoAw'(FifoDepth-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/erg_front.sv -----
module erg_front import erg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic                 start_req,
	input  logic                 echo,
	input  logic [7:0]           trig_ticks,
	input  logic [TickWidth-1:0] wait_limit,
	input  logic [DivWidth-1:0]  ticks_cm,
	output job_t                 job
);

	phase_t               phase_q, phase_d;
	logic [TickWidth-1:0] cnt_q, cnt_d;
	logic [TickWidth-1:0] trig_len;
	logic [TickWidth-1:0] cnt_inc;

	assign trig_len = (trig_ticks == '0) ? TickWidth'(1) : TickWidth'(trig_ticks);
	assign cnt_inc  = cnt_q + 1'b1;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					if (trig_len == TickWidth'(1)) begin
						phase_d = PH_WAIT;
						cnt_d   = '0;
					end else begin
						phase_d = PH_TRIG;
						cnt_d   = TickWidth'(1);
					end
				end
			end
			PH_TRIG: begin
				if (cnt_inc >= trig_len) begin
					phase_d = PH_WAIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_WAIT: begin
				priority if (echo) begin
					phase_d = PH_MEAS;
					cnt_d   = TickWidth'(1);
				end else if (cnt_q >= wait_limit) begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_MEAS: begin
				if (echo) begin
					if (cnt_q < CountMax) begin
						cnt_d = cnt_inc;
					end
				end else begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_comb begin
		job         = '0;
		job.divisor = (ticks_cm == '0) ? DivWidth'(1) : ticks_cm;
		unique case (phase_q)
			PH_IDLE: job.trigger = start_req;
			PH_TRIG: job.trigger = 1'b1;
			PH_WAIT: begin
				if (!echo && cnt_q >= wait_limit) begin
					job.done_res  = 1'b1;
					job.timed_out = 1'b1;
				end
			end
			PH_MEAS: begin
				if (!echo) begin
					job.done_res = 1'b1;
					job.meas     = 1'b1;
					job.ticks    = (cnt_q > TicksSat) ? {TicksWidth{1'b1}} :
						cnt_q[TicksWidth-1:0];
				end
			end
			default: job.trigger = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- hdl/erg_back.sv -----
module erg_back import erg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t job,
	input  logic job_empty,
	output logic job_pop,
	input  logic pop,
	output logic empty,
	output res_t res
);

	bk_state_t             state_q, state_d;
	logic [TicksWidth-1:0] quo_q;
	logic [DivWidth-1:0]   rem_q;
	logic [DivWidth-1:0]   dv_q;
	logic [3:0]            step_q;
	logic [11:0]           val_q;
	logic [TenWidth-1:0]   ten_q;
	logic [TicksWidth-1:0] ticks_q;
	logic                  out_vld_q;
	res_t                  out_q;

	logic                  out_free;
	logic [DivWidth:0]     r2;
	logic                  ge;
	logic [DivWidth-1:0]   rn;
	logic                  ten_ge;
	logic                  load_direct;
	logic                  load_div;
	logic                  start_div;

	assign out_free = !out_vld_q || pop;
	assign empty    = !out_vld_q;
	assign res      = out_q;

	// one restoring step a cycle
	assign r2     = {rem_q, quo_q[TicksWidth-1]};
	assign ge     = r2 >= {1'b0, dv_q};
	assign rn     = ge ? DivWidth'(r2 - {1'b0, dv_q}) : r2[DivWidth-1:0];
	assign ten_ge = val_q >= {4'b0, dv_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty && job.meas) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == 4'(TicksWidth-1)) begin
					state_d = BK_TEN;
				end
			end
			BK_TEN: begin
				if (!ten_ge && out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop     = 1'b0;
		load_direct = 1'b0;
		load_div    = 1'b0;
		start_div   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					if (job.meas) begin
						job_pop   = 1'b1;
						start_div = 1'b1;
					end else if (out_free) begin
						job_pop     = 1'b1;
						load_direct = 1'b1;
					end
				end
			end
			BK_DIV: job_pop = 1'b0;
			BK_TEN: load_div = !ten_ge && out_free;
			default: job_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start_div) begin
			quo_q   <= job.ticks;
			ticks_q <= job.ticks;
			rem_q   <= '0;
			dv_q    <= job.divisor;
			step_q  <= '0;
		end else if (state_q == BK_DIV) begin
			quo_q  <= {quo_q[TicksWidth-2:0], ge};
			rem_q  <= rn;
			step_q <= step_q + 1'b1;
			if (step_q == 4'(TicksWidth-1)) begin
				// remainder times ten, then subtract the divisor to find the tenths digit
				val_q <= {1'b0, rn, 3'b0} + {3'b0, rn, 1'b0};
				ten_q <= '0;
			end
		end else if (state_q == BK_TEN && ten_ge) begin
			val_q <= val_q - {4'b0, dv_q};
			ten_q <= ten_q + 1'b1;
		end
		if (load_direct) begin
			out_q.trigger     <= job.trigger;
			out_q.done_res    <= job.done_res;
			out_q.timed_out   <= job.timed_out;
			out_q.echo_ticks  <= '0;
			out_q.dist_cm     <= '0;
			out_q.dist_tenths <= '0;
		end else if (load_div) begin
			out_q.trigger     <= 1'b0;
			out_q.done_res    <= 1'b1;
			out_q.timed_out   <= 1'b0;
			out_q.echo_ticks  <= ticks_q;
			out_q.dist_cm     <= quo_q;
			out_q.dist_tenths <= ten_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_direct || load_div) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/ultrasonic_echo_ranger_top.sv -----
// Ultrasonic echo ranger.
// Input queue side: one request per microsecond tick carrying start_req and the
// sampled echo level; it is taken when push is high and full is low.
// Result side: exactly one result per request, in order, shown while empty is
// low and taken when pop is high. Results give the trigger pin level, and at
// the end of a measurement done_res with either a timeout or the echo length
// in ticks, whole centimetres and the tenths digit.
// A request that ends no echo goes via the queue to the result register once it
// is free. One that ends an echo goes to a single restoring divider, which is
// loaded, forms the quotient bit by bit, then the tenths digit by subtraction.
// The front end classifies one request per cycle while full is low; a
// four-entry queue sits before the divider, which takes one echo at a time and
// sets their rate; other ticks go one per cycle while it idles and pop is high.
// Configuration: cfg_we writes register cfg_idx (0 trigger length, 1 echo wait
// limit, 2 ticks per cm) at once; write only while idle.
// Reset clears the phase and counter and empties the queue and result register. When the
// consumer stops popping, the queue fills and full rises; nothing is dropped.
module ultrasonic_echo_ranger_top import erg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  start_req,
	input  logic                  echo,
	output logic                  empty,
	input  logic                  pop,
	output logic                  trigger,
	output logic                  done_res,
	output logic                  timed_out,
	output logic [TicksWidth-1:0] echo_ticks,
	output logic [TicksWidth-1:0] dist_cm,
	output logic [TenWidth-1:0]   dist_tenths,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [TickWidth-1:0]  cfg_data
);

	logic [7:0]           trig_ticks_q;
	logic [TickWidth-1:0] wait_limit_q;
	logic [DivWidth-1:0]  ticks_cm_q;

	logic take;
	job_t job_in;
	job_t job_out;
	logic job_empty;
	logic job_pop;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= 8'd10;
			wait_limit_q <= TickWidth'(100000);
			ticks_cm_q   <= DivWidth'(58);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegTrigTicks: trig_ticks_q <= cfg_data[7:0];
				RegWaitLimit: wait_limit_q <= cfg_data;
				RegTicksCm:   ticks_cm_q   <= cfg_data[DivWidth-1:0];
				default:      trig_ticks_q <= trig_ticks_q;
			endcase
		end
	end

	assign take = push && !full;

	erg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.start_req  (start_req),
		.echo       (echo),
		.trig_ticks (trig_ticks_q),
		.wait_limit (wait_limit_q),
		.ticks_cm   (ticks_cm_q),
		.job        (job_in)
	);

	erg_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (job_in),
		.rd_en   (job_pop),
		.rd_data (job_out),
		.full    (full),
		.empty   (job_empty)
	);

	erg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign trigger     = res.trigger;
	assign done_res    = res.done_res;
	assign timed_out   = res.timed_out;
	assign echo_ticks  = res.echo_ticks;
	assign dist_cm     = res.dist_cm;
	assign dist_tenths = res.dist_tenths;

	a_tenths_digit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> dist_tenths <= TenWidth'(9))
		else $error("tenths digit out of range");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && timed_out) |-> (done_res && echo_ticks == '0 && dist_cm == '0))
		else $error("timeout result carries a count");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !done_res) |-> (!timed_out && echo_ticks == '0 && dist_cm == '0
			&& dist_tenths == '0))
		else $error("non-final result carries measurement fields");

	a_trig_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && trigger) |-> !done_res)
		else $error("trigger and done in one result");

endmodule

// ----- sim/tb_ultrasonic_echo_ranger_top.sv -----
module tb_ultrasonic_echo_ranger_top;
	import erg_pkg::*;

	// counter ceiling: the narrower of the echo counter and the tick counter
	localparam int unsigned EchoCap = (CountWidth >= TickWidth) ? 32'hFFFFF :
		((32'd1 << CountWidth) - 32'd1);
	localparam int HoldCycles = 400;

	class ranging_board;
		logic [DivWidth-1:0]  trig_len;
		logic [TickWidth-1:0] wait_limit;
		logic [DivWidth-1:0]  cm_div;
		phase_t               phase;
		logic [TickWidth-1:0] tick_cnt;
		res_t                 due_readings[$];
		int                   n_ticks, n_read, n_timeouts, n_ranges, n_sat, n_errors;

		function new();
			trig_len   = 8'd10;
			wait_limit = 20'd100000;
			cm_div     = 8'd58;
			phase      = PH_IDLE;
			tick_cnt   = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [TickWidth-1:0] val);
			case (idx)
				RegTrigTicks: trig_len   = val[DivWidth-1:0];
				RegWaitLimit: wait_limit = val;
				RegTicksCm:   cm_div     = val[DivWidth-1:0];
				default: ;
			endcase
		endfunction

		// work out the reading for one accepted request
		function void note_tick(logic go, logic lvl);
			res_t        r;
			int unsigned tlen, dv, cnt;
			r    = '0;
			tlen = (trig_len == 0) ? 1 : trig_len;
			n_ticks++;
			case (phase)
				PH_IDLE: if (go) begin
					r.trigger = 1'b1;
					tick_cnt  = TickWidth'(1);
					if (tick_cnt >= tlen) begin
						phase    = PH_WAIT;
						tick_cnt = '0;
					end else begin
						phase = PH_TRIG;
					end
				end
				PH_TRIG: begin
					r.trigger = 1'b1;
					tick_cnt  = tick_cnt + 1'b1;
					if (tick_cnt >= tlen) begin
						phase    = PH_WAIT;
						tick_cnt = '0;
					end
				end
				PH_WAIT: if (lvl) begin
					phase    = PH_MEAS;
					tick_cnt = TickWidth'(1);
				end else if (tick_cnt >= wait_limit) begin
					r.done_res  = 1'b1;
					r.timed_out = 1'b1;
					phase       = PH_IDLE;
					tick_cnt    = '0;
					n_timeouts++;
				end else begin
					tick_cnt = tick_cnt + 1'b1;
				end
				default: if (lvl) begin
					if (tick_cnt < EchoCap)
						tick_cnt = tick_cnt + 1'b1;
				end else begin
					dv  = (cm_div == 0) ? 1 : cm_div;
					cnt = (tick_cnt > 32'hFFFF) ? 32'hFFFF : tick_cnt;
					if (cnt == 32'hFFFF)
						n_sat++;
					r.done_res    = 1'b1;
					r.echo_ticks  = cnt[TicksWidth-1:0];
					r.dist_cm     = TicksWidth'(cnt / dv);
					r.dist_tenths = TenWidth'(((cnt % dv) * 10) / dv);
					phase         = PH_IDLE;
					tick_cnt      = '0;
					n_ranges++;
				end
			endcase
			due_readings.push_back(r);
		endfunction

		function void field_cmp(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				n_errors++;
			end
		endfunction

		function void check_reading(res_t got);
			res_t want;
			if (due_readings.size() == 0) begin
				$error("result popped with no request pending");
				n_errors++;
				return;
			end
			want = due_readings.pop_front();
			n_read++;
			field_cmp("trigger", want.trigger, got.trigger);
			field_cmp("done_res", want.done_res, got.done_res);
			field_cmp("timed_out", want.timed_out, got.timed_out);
			field_cmp("echo_ticks", want.echo_ticks, got.echo_ticks);
			field_cmp("dist_cm", want.dist_cm, got.dist_cm);
			field_cmp("dist_tenths", want.dist_tenths, got.dist_tenths);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic                  start_req = 1'b0;
	logic                  echo = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  trigger;
	logic                  done_res;
	logic                  timed_out;
	logic [TicksWidth-1:0] echo_ticks;
	logic [TicksWidth-1:0] dist_cm;
	logic [TenWidth-1:0]   dist_tenths;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_idx = '0;
	logic [TickWidth-1:0]  cfg_data = '0;

	ranging_board sb;
	int           burst_left = 0;
	bit           steady = 1'b0;
	bit           hold_req = 1'b0;
	int           hold_cnt = 0;
	int           rx_mode = 0;
	int           rx_cyc = 0;
	int           phase_base;

	ultrasonic_echo_ranger_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.start_req(start_req),
		.echo(echo),
		.empty(empty),
		.pop(pop),
		.trigger(trigger),
		.done_res(done_res),
		.timed_out(timed_out),
		.echo_ticks(echo_ticks),
		.dist_cm(dist_cm),
		.dist_tenths(dist_tenths),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic send_tick(input logic go, input logic lvl);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (!steady && gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push      <= 1'b1;
		start_req <= go;
		echo      <= lvl;
		do @(posedge clk); while (full);
		sb.note_tick(go, lvl);
	endtask

	function automatic logic coin();
		return logic'($urandom_range(0, 1));
	endfunction

	// bring the ranger back to idle, let every reading drain, then write all registers
	task automatic reconfigure(input int unsigned tl, input int unsigned wl,
			input int unsigned dv);
		while (sb.phase != PH_IDLE)
			send_tick(1'b0, sb.phase == PH_WAIT);
		push <= 1'b0;
		while (sb.due_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= RegTrigTicks;
		cfg_data <= TickWidth'(tl);
		@(posedge clk);
		sb.set_reg(RegTrigTicks, TickWidth'(tl));
		cfg_idx  <= RegWaitLimit;
		cfg_data <= TickWidth'(wl);
		@(posedge clk);
		sb.set_reg(RegWaitLimit, TickWidth'(wl));
		cfg_idx  <= RegTicksCm;
		cfg_data <= TickWidth'(dv);
		@(posedge clk);
		sb.set_reg(RegTicksCm, TickWidth'(dv));
		cfg_we <= 1'b0;
	endtask

	// one complete ranging cycle with random content, steered by the predicted phase
	task automatic one_measurement();
		int unsigned low_left, high_left, sel, lim;
		lim = sb.wait_limit;
		sel = $urandom_range(0, 3);
		if (sel == 0 && lim <= 2000)
			low_left = lim + 1;
		else if (sel == 1 && lim <= 2000)
			low_left = lim;
		else
			low_left = $urandom_range(0, (lim < 10) ? lim : 10);
		sel = $urandom_range(0, 99);
		if (sel < 70)
			high_left = $urandom_range(0, 12);
		else if (sel < 96)
			high_left = $urandom_range(13, 60);
		else
			high_left = $urandom_range(61, 200);
		do begin
			case (sb.phase)
				PH_IDLE: send_tick(1'b1, coin());
				PH_TRIG: send_tick(coin(), coin());
				PH_WAIT: if (low_left > 0) begin
					send_tick(coin(), 1'b0);
					low_left--;
				end else begin
					send_tick(coin(), 1'b1);
				end
				default: if (high_left > 0) begin
					send_tick(coin(), 1'b1);
					high_left--;
				end else begin
					send_tick(coin(), 1'b0);
				end
			endcase
		end while (sb.phase != PH_IDLE);
	endtask

	// result side: own stall pattern, plus one long hold-off on request
	initial begin
		res_t got;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.trigger     = trigger;
				got.done_res    = done_res;
				got.timed_out   = timed_out;
				got.echo_ticks  = echo_ticks;
				got.dist_cm     = dist_cm;
				got.dist_tenths = dist_tenths;
				sb.check_reading(got);
			end
			rx_cyc++;
			if (rx_cyc % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_req) begin
				pop <= 1'b0;
				hold_cnt++;
				if (hold_cnt == HoldCycles) begin
					hold_req = 1'b0;
					hold_cnt = 0;
				end
			end else begin
				case (rx_mode)
					0: pop <= 1'b1;
					1: pop <= coin();
					2: pop <= (rx_cyc % 4 == 0);
					default: pop <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	initial begin
		#3_000_000;
		$display("** ultrasonic_echo_ranger_top: FAILED **");
		$finish;
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values; echo high and start held during the trigger are ignored
		repeat (10) send_tick(1'b1, 1'b1);
		repeat (3) send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);

		// zero trigger length, zero wait limit, zero divisor
		reconfigure(0, 0, 0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b0);

		// echo rising exactly at the wait limit, then a timeout at the wait limit with echo low
		reconfigure(1, 1, 1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);

		// tenths digit of nine
		reconfigure(2, 3, 10);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		repeat (19) send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);

		// longest trigger with start and echo held high, then a steady echo
		reconfigure(255, 20'hFFFFF, 1);
		steady = 1'b1;
		send_tick(1'b1, 1'b0);
		repeat (254) send_tick(1'b1, 1'b1);
		repeat (60) send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		steady = 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: reconfigure(3, 12, 58);
				1: reconfigure(0, 0, 255);
				2: reconfigure(1, 4, 7);
				default: reconfigure($urandom_range(0, 6), $urandom_range(0, 20),
					$urandom_range(0, 255));
			endcase
			if (ph == 1)
				hold_req = 1'b1;
			phase_base = sb.n_ticks;
			while (sb.n_ticks - phase_base < 55) begin
				if ($urandom_range(0, 6) == 0)
					repeat ($urandom_range(1, 15)) send_tick(coin(), coin());
				else
					one_measurement();
			end
		end

		push <= 1'b0;
		while (sb.due_readings.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d ticks sent, %0d readings checked", sb.n_ticks, sb.n_read);
		$display("%0d timeouts, %0d echo ranges (%0d saturated), %0d mismatches",
			sb.n_timeouts, sb.n_ranges, sb.n_sat, sb.n_errors);
		if (sb.n_errors == 0 && sb.due_readings.size() == 0)
			$display("** ultrasonic_echo_ranger_top: PASSED **");
		else
			$display("** ultrasonic_echo_ranger_top: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/erg_pkg.sv
hdl/erg_fifo.sv
hdl/erg_front.sv
hdl/erg_back.sv
hdl/ultrasonic_echo_ranger_top.sv
sim/tb_ultrasonic_echo_ranger_top.sv
